### rtl/tcac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcac_pkg
// Types and constants shared by the two-corner aim calibrator.
// ----------------------------------------------------------------------------
package tcac_pkg;

  localparam int FIELD_W    = 16;  // coordinate and edge field width
  localparam int SPAN_W     = 17;  // signed span field width
  localparam int CNT_W      = 16;  // samples_held width
  localparam int SC_W       = 11;  // sample_count register width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_W       = 32;  // u_coord, v_coord
  localparam int OUT_W      = 120; // 116 bits of fields, padded to bytes

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_U_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_V_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_U_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_V_MAX   = 3'd4;

  // edge slots
  localparam int EDGE_UMIN = 0;
  localparam int EDGE_VMIN = 1;
  localparam int EDGE_UMAX = 2;
  localparam int EDGE_VMAX = 3;

  localparam logic [SC_W-1:0] SC_RESET = 11'd16;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_RESET  = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_SAVE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_UPPER_LEFT  = 2'd0,
    PH_LOWER_RIGHT = 2'd1,
    PH_CALIBRATED  = 2'd2,
    PH_SAVED       = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage : tcac_pkg
`default_nettype wire

### rtl/tcac_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcac_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcac_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] trial;
  logic             ge;

  assign rem_sh = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = ~trial[DEN_W+1];

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      rem_nxt = ge ? trial[DEN_W:0] : rem_sh;
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule : tcac_div
`default_nettype wire

### rtl/two_corner_aim_calibrator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_corner_aim_calibrator_top
// Two-corner aim calibration: averages Q12.4 samples into edges and spans.
// ----------------------------------------------------------------------------
// Input stream: in_tuser carries the mode (sample, reset, cancel, save),
// in_tdata the u and v samples. Every input transaction gives exactly one
// output transaction with the held count, phase, working edges and spans.
// An ordinary item passes through the emit state to out_tvalid, and
// in_tready returns in the same cycle as out_tvalid, so no new item is
// taken before the last one is emitted. The sample that completes a
// corner starts two bit-serial dividers (u and v) that run one
// quotient bit per cycle over the sum width SW = min(COORD_BITS,16) +
// clog2(MAX_SAMPLES+1), which is 27 with the default parameters.
// Results sit in an output register: a new item is accepted while the
// previous result waits, and the block holds its next result (and stops
// taking items) until out_tready frees the register.
// Reset (rst_n low, synchronous) returns phase to upper left, clears the
// count and sums, sets sample_count to 16 and all edges and spans to zero.
// Configuration writes are taken in any cycle and apply at once.
// ----------------------------------------------------------------------------
module two_corner_aim_calibrator_top
  import tcac_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int COORD_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_W-1:0]       in_tdata,  // u_coord[15:0], v_coord[31:16]
  input  wire logic [1:0]            in_tuser,  // mode[1:0]
  // output stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // samples_held[15:0], phase[17:16], left_edge[33:18], top_edge[49:34],
  // right_edge[65:50], bottom_edge[81:66], span_u[98:82], span_v[115:99]
  output logic [OUT_W-1:0]           out_tdata
);

  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = CW + DW;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [SC_W-1:0] sample_count_r, sample_count_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [SW-1:0]   sum_u_r, sum_u_nxt;
  logic [SW-1:0]   sum_v_r, sum_v_nxt;
  logic [CW-1:0]   work_edge_r [4];
  logic [CW-1:0]   work_edge_nxt [4];
  logic [CW-1:0]   saved_edge_r [4];
  logic [CW-1:0]   saved_edge_nxt [4];
  logic [CW:0]     work_span_r [2];
  logic [CW:0]     work_span_nxt [2];
  logic [CW:0]     saved_span_r [2];
  logic [CW:0]     saved_span_nxt [2];
  logic            out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  mode_t           in_mode;
  logic [CW-1:0]   in_u, in_v;
  logic [CNT_W-1:0] held_inc;
  logic [CNT_W-1:0] sc_ext;
  logic [CNT_W-1:0] eff_count;
  logic            div_start;
  logic            div_done_u, div_done_v;
  logic [SW-1:0]   quo_u, quo_v;
  logic [CW-1:0]   avg_u, avg_v;

  assign in_mode   = mode_t'(in_tuser);
  assign in_u      = in_tdata[CW-1:0];
  assign in_v      = in_tdata[FIELD_W+CW-1:FIELD_W];
  assign held_inc  = held_r + CNT_W'(1);
  assign sc_ext    = CNT_W'(sample_count_r);
  assign eff_count = (sample_count_r == '0) ? CNT_W'(1) :
                     ((sc_ext > MAX_CNT) ? MAX_CNT : sc_ext);
  assign avg_u     = quo_u[CW-1:0];
  assign avg_v     = quo_v[CW-1:0];

  tcac_div #(
    .NUM_W (SW),
    .DEN_W (DW)
  ) u_div_u (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_u_r),
    .den   (held_r[DW-1:0]),
    .done  (div_done_u),
    .quo   (quo_u)
  );

  tcac_div #(
    .NUM_W (SW),
    .DEN_W (DW)
  ) u_div_v (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_v_r),
    .den   (held_r[DW-1:0]),
    .done  (div_done_v),
    .quo   (quo_v)
  );

  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    sample_count_nxt = sample_count_r;
    held_nxt         = held_r;
    sum_u_nxt        = sum_u_r;
    sum_v_nxt        = sum_v_r;
    work_edge_nxt    = work_edge_r;
    saved_edge_nxt   = saved_edge_r;
    work_span_nxt    = work_span_r;
    saved_span_nxt   = saved_span_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    div_start        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_addr)
        CFG_SAMPLE_COUNT: sample_count_nxt = cfg_wdata[SC_W-1:0];
        CFG_INIT_U_MIN: begin
          work_edge_nxt[EDGE_UMIN]  = cfg_wdata[CW-1:0];
          saved_edge_nxt[EDGE_UMIN] = cfg_wdata[CW-1:0];
        end
        CFG_INIT_V_MIN: begin
          work_edge_nxt[EDGE_VMIN]  = cfg_wdata[CW-1:0];
          saved_edge_nxt[EDGE_VMIN] = cfg_wdata[CW-1:0];
        end
        CFG_INIT_U_MAX: begin
          work_edge_nxt[EDGE_UMAX]  = cfg_wdata[CW-1:0];
          saved_edge_nxt[EDGE_UMAX] = cfg_wdata[CW-1:0];
        end
        CFG_INIT_V_MAX: begin
          work_edge_nxt[EDGE_VMAX]  = cfg_wdata[CW-1:0];
          saved_edge_nxt[EDGE_VMAX] = cfg_wdata[CW-1:0];
        end
        default: ;
      endcase
      // an edge write recomputes both copies of the spans from their edges
      if (cfg_addr == CFG_INIT_U_MIN || cfg_addr == CFG_INIT_V_MIN ||
          cfg_addr == CFG_INIT_U_MAX || cfg_addr == CFG_INIT_V_MAX) begin
        work_span_nxt[0]  = {1'b0, work_edge_nxt[EDGE_UMAX]} -
                            {1'b0, work_edge_nxt[EDGE_UMIN]};
        work_span_nxt[1]  = {1'b0, work_edge_nxt[EDGE_VMAX]} -
                            {1'b0, work_edge_nxt[EDGE_VMIN]};
        saved_span_nxt[0] = {1'b0, saved_edge_nxt[EDGE_UMAX]} -
                            {1'b0, saved_edge_nxt[EDGE_UMIN]};
        saved_span_nxt[1] = {1'b0, saved_edge_nxt[EDGE_VMAX]} -
                            {1'b0, saved_edge_nxt[EDGE_VMIN]};
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EMIT;
          case (in_mode)
            MODE_SAMPLE: begin
              if (phase_r == PH_CALIBRATED || phase_r == PH_SAVED) begin
                if (held_r != CNT_SAT) begin
                  held_nxt = held_inc;
                end
              end else begin
                held_nxt  = held_inc;
                sum_u_nxt = sum_u_r + SW'(in_u);
                sum_v_nxt = sum_v_r + SW'(in_v);
                if (held_inc >= eff_count) begin
                  state_nxt = ST_LOAD;
                end
              end
            end
            MODE_RESET: begin
              held_nxt  = '0;
              sum_u_nxt = '0;
              sum_v_nxt = '0;
              phase_nxt = PH_UPPER_LEFT;
            end
            MODE_CANCEL: begin
              held_nxt      = '0;
              sum_u_nxt     = '0;
              sum_v_nxt     = '0;
              phase_nxt     = PH_UPPER_LEFT;
              work_edge_nxt = saved_edge_r;
              work_span_nxt = saved_span_r;
            end
            MODE_SAVE: begin
              saved_edge_nxt = work_edge_r;
              saved_span_nxt = work_span_r;
              phase_nxt      = PH_SAVED;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done_u && div_done_v) begin
          held_nxt  = '0;
          sum_u_nxt = '0;
          sum_v_nxt = '0;
          if (phase_r == PH_UPPER_LEFT) begin
            work_edge_nxt[EDGE_UMIN] = avg_u;
            work_edge_nxt[EDGE_VMIN] = avg_v;
            phase_nxt                = PH_LOWER_RIGHT;
          end else begin
            work_edge_nxt[EDGE_UMAX] = avg_u;
            work_edge_nxt[EDGE_VMAX] = avg_v;
            work_span_nxt[0] = {1'b0, avg_u} - {1'b0, work_edge_r[EDGE_UMIN]};
            work_span_nxt[1] = {1'b0, avg_v} - {1'b0, work_edge_r[EDGE_VMIN]};
            phase_nxt        = PH_CALIBRATED;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000,
                           SPAN_W'(work_span_r[1]),
                           SPAN_W'(work_span_r[0]),
                           FIELD_W'(work_edge_r[EDGE_VMAX]),
                           FIELD_W'(work_edge_r[EDGE_UMAX]),
                           FIELD_W'(work_edge_r[EDGE_VMIN]),
                           FIELD_W'(work_edge_r[EDGE_UMIN]),
                           phase_r,
                           held_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      phase_r        <= PH_UPPER_LEFT;
      sample_count_r <= SC_RESET;
      held_r         <= '0;
      sum_u_r        <= '0;
      sum_v_r        <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        work_edge_r[i]  <= '0;
        saved_edge_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        work_span_r[i]  <= '0;
        saved_span_r[i] <= '0;
      end
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      sample_count_r <= sample_count_nxt;
      held_r         <= held_nxt;
      sum_u_r        <= sum_u_nxt;
      sum_v_r        <= sum_v_nxt;
      out_valid_r    <= out_valid_nxt;
      work_edge_r    <= work_edge_nxt;
      saved_edge_r   <= saved_edge_nxt;
      work_span_r    <= work_span_nxt;
      saved_span_r   <= saved_span_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : two_corner_aim_calibrator_top
`default_nettype wire

### sim/two_corner_aim_calibrator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_corner_aim_calibrator_top_tb
// Self-checking bench for the two-corner aim calibrator. A behavioral
// predictor tracks corner averaging, held-count saturation, save, cancel,
// reset and initial-edge loads; every output transaction is compared field
// by field with the readout predicted for the oldest accepted item.
// ----------------------------------------------------------------------------
module two_corner_aim_calibrator_top_tb;
  import tcac_pkg::*;

  localparam int MAX_SAMP    = 1024;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 64;
  localparam int RAND_ITEMS  = 125;

  typedef struct packed {
    logic [CNT_W-1:0]   held;
    logic [1:0]         ph;
    logic [FIELD_W-1:0] left_e;
    logic [FIELD_W-1:0] top_e;
    logic [FIELD_W-1:0] right_e;
    logic [FIELD_W-1:0] bottom_e;
    logic [SPAN_W-1:0]  span_u;
    logic [SPAN_W-1:0]  span_v;
  } readout_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // u_coord[15:0], v_coord[31:16]
  logic [1:0]            in_tuser;   // mode[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  // samples_held, phase, left, top, right, bottom, span_u, span_v
  logic [OUT_W-1:0]      out_tdata;

  // predictor state
  logic [SC_W-1:0]    corner_count_cfg;
  phase_t             cal_phase;
  logic [CNT_W-1:0]   held_cnt;
  logic [31:0]        sum_u_acc;
  logic [31:0]        sum_v_acc;
  logic [FIELD_W-1:0] work_edge [4];
  logic [FIELD_W-1:0] saved_edge [4];
  logic [SPAN_W-1:0]  work_span [2];
  logic [SPAN_W-1:0]  saved_span [2];

  readout_t expected_readouts[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_cnt = 0;
  int items_sent = 0;
  int readouts_checked = 0;
  int corners_taken = 0;
  int cycle_cnt = 0;

  two_corner_aim_calibrator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver backpressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [SPAN_W-1:0] span_between(logic [FIELD_W-1:0] hi,
                                                     logic [FIELD_W-1:0] lo);
    return {1'b0, hi} - {1'b0, lo};
  endfunction

  function automatic void clear_corner();
    held_cnt  = '0;
    sum_u_acc = '0;
    sum_v_acc = '0;
    cal_phase = PH_UPPER_LEFT;
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    int slot;
    slot = -1;
    case (idx)
      CFG_SAMPLE_COUNT: corner_count_cfg = val[SC_W-1:0];
      CFG_INIT_U_MIN:   slot = EDGE_UMIN;
      CFG_INIT_V_MIN:   slot = EDGE_VMIN;
      CFG_INIT_U_MAX:   slot = EDGE_UMAX;
      CFG_INIT_V_MAX:   slot = EDGE_VMAX;
      default: ;
    endcase
    if (slot >= 0) begin
      work_edge[slot]  = val;
      saved_edge[slot] = val;
      work_span[0]  = span_between(work_edge[EDGE_UMAX], work_edge[EDGE_UMIN]);
      work_span[1]  = span_between(work_edge[EDGE_VMAX], work_edge[EDGE_VMIN]);
      saved_span[0] = span_between(saved_edge[EDGE_UMAX], saved_edge[EDGE_UMIN]);
      saved_span[1] = span_between(saved_edge[EDGE_VMAX], saved_edge[EDGE_VMIN]);
    end
  endfunction

  function automatic readout_t predict_readout(mode_t m, logic [FIELD_W-1:0] u,
                                               logic [FIELD_W-1:0] v);
    readout_t r;
    int eff;
    logic [31:0] avg_u;
    logic [31:0] avg_v;
    case (m)
      MODE_SAMPLE: begin
        if (cal_phase == PH_CALIBRATED || cal_phase == PH_SAVED) begin
          if (held_cnt != '1) held_cnt = held_cnt + 1'b1;
        end else begin
          held_cnt  = held_cnt + 1'b1;
          sum_u_acc = sum_u_acc + u;
          sum_v_acc = sum_v_acc + v;
          eff = (corner_count_cfg == 0) ? 1 :
                (corner_count_cfg > MAX_SAMP) ? MAX_SAMP : int'(corner_count_cfg);
          if (int'(held_cnt) >= eff) begin
            avg_u = sum_u_acc / {16'd0, held_cnt};
            avg_v = sum_v_acc / {16'd0, held_cnt};
            held_cnt  = '0;
            sum_u_acc = '0;
            sum_v_acc = '0;
            if (cal_phase == PH_UPPER_LEFT) begin
              work_edge[EDGE_UMIN] = avg_u[FIELD_W-1:0];
              work_edge[EDGE_VMIN] = avg_v[FIELD_W-1:0];
              cal_phase = PH_LOWER_RIGHT;
            end else begin
              work_edge[EDGE_UMAX] = avg_u[FIELD_W-1:0];
              work_edge[EDGE_VMAX] = avg_v[FIELD_W-1:0];
              // spans only follow the edges when the lower right corner lands
              work_span[0] = span_between(work_edge[EDGE_UMAX], work_edge[EDGE_UMIN]);
              work_span[1] = span_between(work_edge[EDGE_VMAX], work_edge[EDGE_VMIN]);
              cal_phase = PH_CALIBRATED;
            end
            corners_taken++;
          end
        end
      end
      MODE_RESET: clear_corner();
      MODE_CANCEL: begin
        clear_corner();
        work_edge = saved_edge;
        work_span = saved_span;
      end
      default: begin
        saved_edge = work_edge;
        saved_span = work_span;
        cal_phase  = PH_SAVED;
      end
    endcase
    r.held     = held_cnt;
    r.ph       = cal_phase;
    r.left_e   = work_edge[EDGE_UMIN];
    r.top_e    = work_edge[EDGE_VMIN];
    r.right_e  = work_edge[EDGE_UMAX];
    r.bottom_e = work_edge[EDGE_VMAX];
    r.span_u   = work_span[0];
    r.span_v   = work_span[1];
    return r;
  endfunction

  task automatic check_field(string name, logic [SPAN_W-1:0] want,
                             logic [SPAN_W-1:0] got);
    if (want !== got) begin
      fail_cnt++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : readout_check
    readout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readouts.size() == 0) begin
        fail_cnt++;
        $error("output transaction with no readout pending");
      end else begin
        want = expected_readouts.pop_front();
        readouts_checked++;
        check_field("samples_held", want.held, out_tdata[15:0]);
        check_field("phase", want.ph, out_tdata[17:16]);
        check_field("left_edge", want.left_e, out_tdata[33:18]);
        check_field("top_edge", want.top_e, out_tdata[49:34]);
        check_field("right_edge", want.right_e, out_tdata[65:50]);
        check_field("bottom_edge", want.bottom_e, out_tdata[81:66]);
        check_field("span_u", want.span_u, out_tdata[98:82]);
        check_field("span_v", want.span_v, out_tdata[115:99]);
      end
    end
  end

  task automatic send_item(mode_t m, logic [FIELD_W-1:0] u, logic [FIELD_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {v, u};
    do @(posedge clk); while (!in_tready);
    expected_readouts.insert(expected_readouts.size(), predict_readout(m, u, v));
    items_sent++;
  endtask

  // lower valid and hold off until every readout is back
  task automatic drain_readouts();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    load_register(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return FIELD_W'($urandom);
  endfunction

  task automatic set_pressure(int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task automatic test_edge_loads();
    set_pressure(0, 0);
    write_register(CFG_INIT_U_MIN, 16'hFFFF);
    write_register(CFG_INIT_V_MIN, 16'h0000);
    write_register(CFG_INIT_U_MAX, 16'h0000);
    write_register(CFG_INIT_V_MAX, 16'hFFFF);
    send_item(MODE_RESET, 16'h1234, 16'h5678);
    send_item(MODE_SAVE, 16'hFFFF, 16'hFFFF);
    send_item(MODE_CANCEL, 16'h0000, 16'h0000);
    drain_readouts();
    write_register(CFG_INIT_U_MIN, 16'h0000);
    write_register(CFG_INIT_V_MIN, 16'hFFFF);
    write_register(CFG_INIT_U_MAX, 16'hFFFF);
    write_register(CFG_INIT_V_MAX, 16'h0000);
    send_item(MODE_RESET, 16'h0000, 16'h0000);
    drain_readouts();
  endtask

  task automatic test_mode_sequence();
    set_pressure(20, 20);
    // a count of zero behaves as one sample per corner
    write_register(CFG_SAMPLE_COUNT, 16'h0000);
    send_item(MODE_SAMPLE, 16'h0000, 16'h0000);
    send_item(MODE_SAMPLE, 16'hFFFF, 16'hFFFF);
    send_item(MODE_SAMPLE, 16'h1234, 16'hABCD);
    send_item(MODE_SAVE, 16'h0000, 16'h0000);
    send_item(MODE_SAMPLE, 16'h5555, 16'hAAAA);
    send_item(MODE_RESET, 16'hFFFF, 16'hFFFF);
    send_item(MODE_SAMPLE, 16'hFFFF, 16'h0000);
    // right edge lands left of the left edge: span_u goes negative
    send_item(MODE_SAMPLE, 16'h0000, 16'hFFFF);
    send_item(MODE_CANCEL, 16'h0000, 16'h0000);
    send_item(MODE_SAMPLE, 16'h8000, 16'h7FFF);
    send_item(MODE_SAVE, 16'h0000, 16'h0000);
    send_item(MODE_SAMPLE, 16'hAAAA, 16'h5555);
    send_item(MODE_SAMPLE, 16'h0001, 16'hFFFE);
    send_item(MODE_CANCEL, 16'hFFFF, 16'hFFFF);
    send_item(MODE_SAVE, 16'h0000, 16'h0000);
    send_item(MODE_RESET, 16'h0000, 16'h0000);
    drain_readouts();
  endtask

  task automatic test_count_lowered();
    set_pressure(0, 20);
    write_register(CFG_SAMPLE_COUNT, 16'd6);
    send_item(MODE_SAMPLE, 16'hFFFF, 16'h0003);
    send_item(MODE_SAMPLE, 16'hFFFE, 16'h0000);
    send_item(MODE_SAMPLE, 16'h0001, 16'h0000);
    drain_readouts();
    // fourth sample lands on a count of two: the average divides by four
    write_register(CFG_SAMPLE_COUNT, 16'd2);
    send_item(MODE_SAMPLE, 16'h0007, 16'hFFFF);
    send_item(MODE_SAMPLE, 16'h0100, 16'h0200);
    drain_readouts();
    write_register(CFG_SAMPLE_COUNT, 16'd3);
    send_item(MODE_SAMPLE, 16'h0300, 16'h0400);
    send_item(MODE_SAMPLE, 16'h0500, 16'h0001);
    drain_readouts();
  endtask

  task automatic test_count_clamp();
    set_pressure(0, 0);
    // 2047 in the register acts as the 1024-sample ceiling: a short burst takes no corner
    write_register(CFG_SAMPLE_COUNT, 16'hFFFF);
    send_item(MODE_RESET, 16'h0000, 16'h0000);
    repeat (16) send_item(MODE_SAMPLE, 16'hFFFF, rand_coord());
    send_item(MODE_RESET, 16'h0000, 16'h0000);
    drain_readouts();
  endtask

  task automatic test_held_past_calibration();
    set_pressure(0, 0);
    write_register(CFG_SAMPLE_COUNT, 16'd1);
    send_item(MODE_RESET, 16'h0000, 16'h0000);
    send_item(MODE_SAMPLE, rand_coord(), rand_coord());
    send_item(MODE_SAMPLE, rand_coord(), rand_coord());
    repeat (4) send_item(MODE_SAMPLE, FIELD_W'($urandom), FIELD_W'($urandom));
    send_item(MODE_SAVE, 16'h0000, 16'h0000);
    send_item(MODE_SAMPLE, 16'hFFFF, 16'hFFFF);
    send_item(MODE_RESET, 16'h0000, 16'h0000);
    drain_readouts();
  endtask

  task automatic test_random_traffic();
    int p;
    int n;
    int pick;
    logic [CFG_DATA_W-1:0] cnt_val;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: set_pressure(0, 0);
        1: set_pressure(84, 0);
        2: set_pressure(0, 84);
        default: set_pressure(20, 20);
      endcase
      pick = $urandom_range(4);
      cnt_val = (pick == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      // upper bits beyond the 11-bit register are dropped
      cnt_val = cnt_val | (16'($urandom_range(31)) << SC_W);
      write_register(CFG_SAMPLE_COUNT, cnt_val);
      write_register(CFG_INIT_U_MIN, rand_coord());
      write_register(CFG_INIT_V_MIN, rand_coord());
      write_register(CFG_INIT_U_MAX, rand_coord());
      write_register(CFG_INIT_V_MAX, rand_coord());
      for (n = 0; n < RAND_ITEMS; n++) begin
        if (p == 1 && n == RAND_ITEMS / 2) drain_readouts();
        pick = $urandom_range(99);
        if (pick < 80)      send_item(MODE_SAMPLE, rand_coord(), rand_coord());
        else if (pick < 87) send_item(MODE_RESET, rand_coord(), rand_coord());
        else if (pick < 94) send_item(MODE_CANCEL, rand_coord(), rand_coord());
        else                send_item(MODE_SAVE, rand_coord(), rand_coord());
      end
      drain_readouts();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_SAMPLE_COUNT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_SAMPLE;
    corner_count_cfg = SC_RESET;
    for (int i = 0; i < 4; i++) begin
      work_edge[i]  = '0;
      saved_edge[i] = '0;
    end
    work_span[0]  = '0;
    work_span[1]  = '0;
    saved_span[0] = '0;
    saved_span[1] = '0;
    clear_corner();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_loads();
    test_mode_sequence();
    test_count_lowered();
    test_count_clamp();
    test_held_past_calibration();
    test_random_traffic();

    drain_readouts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_readouts.size() != 0) fail_cnt++;
    $display("run: %0d items, %0d readouts checked, %0d corners averaged", items_sent,
             readouts_checked, corners_taken);
    $display("run: edge loads, count clamp and lowering, held count past calibration, four stall mixes");
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/tcac_pkg.sv
rtl/tcac_div.sv
rtl/two_corner_aim_calibrator_top.sv
sim/two_corner_aim_calibrator_top_tb.sv
